>>> hw/rtl/sloc_pkg.sv
// Shared types and constants for the store/load overlap checker.
// Depends on nothing; used by sloc_cell and store_load_overlap_checker_unit.
package sloc_pkg;

	// Number of store entries, one per cell
	localparam int DEPTH = 64;

	// Field widths
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 4;
	localparam int CNT_W  = 7;

	// Command kinds
	localparam logic [1:0] KIND_STORE = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_FEW     = 2'd2;
	localparam logic [1:0] ST_BADSIZE = 2'd3;

	// Mode register codes
	localparam logic [1:0] MODE_REAL   = 2'd0;
	localparam logic [1:0] MODE_NEVER  = 2'd1;
	localparam logic [1:0] MODE_ALWAYS = 2'd2;

	// Input word
	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] nbytes;
		logic [CNT_W-1:0]  stores_to_check;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic       conflict;
		logic [1:0] status;
	} res_t;

	// One stored entry held by a cell
	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} ent_t;

	// Load probe walking down the chain
	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		logic [CNT_W-1:0]  rem;
	} tok_t;

	// Per-cell walk outcome
	typedef struct packed {
		logic       done;
		logic       conflict;
		logic [1:0] status;
	} rpt_t;

endpackage

>>> hw/rtl/sloc_cell.sv
// One cell of the store chain: holds one store entry and evaluates the load probe.
// Depends on sloc_pkg.
module sloc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           flush,
	input  sloc_pkg::ent_t ent_in,
	output sloc_pkg::ent_t ent_out,
	input  sloc_pkg::tok_t tok_in,
	output sloc_pkg::tok_t tok_out,
	output sloc_pkg::rpt_t rpt
);

	sloc_pkg::ent_t ent_q;
	sloc_pkg::tok_t tok_q;

	logic                      word_eq;
	logic [sloc_pkg::SIZE_W-1:0] big;
	logic [2:0]                diff;
	logic                      hit;
	logic                      bad;

	// Entry shifts toward older cells on a push; flush drops it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (push) begin
			ent_q <= ent_in;
		end else if (flush) begin
			ent_q.vld <= 1'b0;
		end
	end

	// Probe register, refilled from the neighbor every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// Overlap test against the held entry
	always_comb begin
		word_eq = (ent_q.addr[sloc_pkg::ADDR_W-1:3] == tok_q.addr[sloc_pkg::ADDR_W-1:3]);
		big     = (ent_q.size >= tok_q.size) ? ent_q.size : tok_q.size;
		diff    = ent_q.addr[2:0] ^ tok_q.addr[2:0];
		hit     = 1'b0;
		bad     = 1'b0;
		case (big)
			4'd8:    hit = 1'b1;
			4'd4:    hit = ~diff[2];
			4'd2:    hit = (diff[2:1] == 2'b00);
			4'd1:    hit = (diff == 3'b000);
			default: bad = 1'b1;
		endcase
		hit = hit & word_eq;
		bad = bad & word_eq;
	end

	// Walk step: stop, or pass the probe on with one fewer to check
	always_comb begin
		rpt     = '0;
		tok_out = tok_q;
		tok_out.rem = tok_q.rem - sloc_pkg::CNT_W'(1);
		if (tok_q.vld) begin
			if (tok_q.rem == '0) begin
				rpt.done   = 1'b1;
				rpt.status = sloc_pkg::ST_OK;
			end else if (!ent_q.vld) begin
				rpt.done   = 1'b1;
				rpt.status = sloc_pkg::ST_FEW;
			end else if (bad) begin
				rpt.done   = 1'b1;
				rpt.status = sloc_pkg::ST_BADSIZE;
			end else if (hit) begin
				rpt.done     = 1'b1;
				rpt.conflict = 1'b1;
				rpt.status   = sloc_pkg::ST_OK;
			end
		end
		tok_out.vld = tok_q.vld & ~rpt.done;
	end

	assign ent_out = ent_q;

endmodule

>>> hw/rtl/store_load_overlap_checker_unit.sv
// Top level of the store/load overlap checker: command port, config port, cell chain.
// Depends on sloc_pkg and sloc_cell.
//
// Usage:
//   A command word (cmd) is taken at a rising edge with start high and busy low.
//   Every command gives exactly one result word, shown on result for one cycle
//   with done high; the receiver must take it then, it cannot stall.
//   Store and flush (and the unused kind) answer straight from the result register
//   and keep busy low, so they can be issued every cycle.
//   A load sends a probe into a chain of 64 cells, newest store in cell 0;
//   the probe moves one cell per cycle and stops at the first overlap, a bad
//   size, an empty cell, or when its check count runs out. A load that stops
//   at cell k answers once its probe has passed cells 0 to k and its result is
//   registered; busy is high for that whole walk. The chain length sets the worst case.
//   The mode register is written on the cfg channel (cfg_ready is always
//   high); write it only while no command is pending.
//   Reset empties the buffer, clears the mode and drops any walk in flight.
module store_load_overlap_checker_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sloc_pkg::cmd_t     cmd,
	output logic               done,
	output sloc_pkg::res_t     result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data
);

	logic [1:0]     mode_q;
	logic           busy_q;
	logic           done_q;
	sloc_pkg::res_t res_q;
	sloc_pkg::tok_t tail_q;

	logic           accept;
	logic           full;
	logic           push;
	logic           flush;

	sloc_pkg::ent_t ent_w [sloc_pkg::DEPTH];
	sloc_pkg::ent_t new_ent;
	sloc_pkg::tok_t head_tok;
	sloc_pkg::tok_t tok_w [sloc_pkg::DEPTH+1];
	sloc_pkg::rpt_t rpt_w [sloc_pkg::DEPTH];

	sloc_pkg::rpt_t walk;
	sloc_pkg::res_t res_d;
	logic           done_d;

	// Command decode
	assign accept = start & ~busy_q;
	assign full   = ent_w[sloc_pkg::DEPTH-1].vld;
	assign push   = accept & (cmd.kind == sloc_pkg::KIND_STORE) & ~full;
	assign flush  = accept & (cmd.kind == sloc_pkg::KIND_FLUSH);

	// New entry and probe into the head of the chain
	always_comb begin
		new_ent.vld  = 1'b1;
		new_ent.addr = cmd.addr;
		new_ent.size = cmd.nbytes;
		head_tok.vld  = accept & (cmd.kind == sloc_pkg::KIND_LOAD);
		head_tok.addr = cmd.addr;
		head_tok.size = cmd.nbytes;
		head_tok.rem  = cmd.stores_to_check;
	end

	assign tok_w[0] = head_tok;

	// Cell chain
	for (genvar i = 0; i < sloc_pkg::DEPTH; i++) begin : g_cell
		sloc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.push    (push),
			.flush   (flush),
			.ent_in  ((i == 0) ? new_ent : ent_w[(i == 0) ? 0 : i-1]),
			.ent_out (ent_w[i]),
			.tok_in  (tok_w[i]),
			.tok_out (tok_w[i+1]),
			.rpt     (rpt_w[i])
		);
	end

	// Probe that left the last cell: out of stores unless nothing is left to check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
		end else begin
			tail_q <= tok_w[sloc_pkg::DEPTH];
		end
	end

	// Gather the walk outcome; at most one source is active
	always_comb begin
		walk = '0;
		for (int i = 0; i < sloc_pkg::DEPTH; i++) begin
			walk = walk | rpt_w[i];
		end
		if (tail_q.vld) begin
			walk.done   = 1'b1;
			walk.status = (tail_q.rem == '0) ? sloc_pkg::ST_OK : sloc_pkg::ST_FEW;
		end
	end

	// Next result word
	always_comb begin
		done_d = 1'b0;
		res_d  = '0;
		if (walk.done) begin
			done_d       = 1'b1;
			res_d.status = walk.status;
			unique case (mode_q)
				sloc_pkg::MODE_NEVER:  res_d.conflict = 1'b0;
				sloc_pkg::MODE_ALWAYS: res_d.conflict = 1'b1;
				default:               res_d.conflict = walk.conflict;
			endcase
		end else if (accept && cmd.kind != sloc_pkg::KIND_LOAD) begin
			done_d = 1'b1;
			if (cmd.kind == sloc_pkg::KIND_STORE && full) begin
				res_d.status = sloc_pkg::ST_FULL;
			end
		end
	end

	// Result register and walk-in-progress flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= done_d;
			res_q  <= res_d;
			if (accept && cmd.kind == sloc_pkg::KIND_LOAD) begin
				busy_q <= 1'b1;
			end else if (walk.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sloc_pkg::MODE_REAL;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = res_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for store_load_overlap_checker_unit: directed and random
// store/load/flush words, a built-in overlap predictor, and result checks.
// Depends on sloc_pkg and the store_load_overlap_checker_unit RTL.
module testbench;
	import sloc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] KIND_NONE     = 2'd3;
	localparam logic [1:0] MODE_REAL_ALT = 2'd3;

	// Pending stimulus: a command word or a mode write
	typedef struct packed {
		logic       is_cfg;
		logic [1:0] mode;
		cmd_t       c;
		logic [6:0] idle_pct;
	} stim_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	cmd_t   cmd = '0;
	logic   done;
	res_t   result;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic [1:0] cfg_data = MODE_REAL;

	stim_t cmd_q[$];
	res_t  verdict_q[$];
	res_t  want;
	int    n_sent = 0;
	int    n_seen = 0;
	int    n_fail = 0;

	// Predictor state
	logic [ADDR_W-1:0] buf_addr [DEPTH];
	logic [SIZE_W-1:0] buf_size [DEPTH];
	int                buf_fill = 0;
	logic [1:0]        mode_now = MODE_REAL;

	// Generator state
	int         gen_fill = 0;
	int         gap_pct = 21;
	int         n_made = 0;

	store_load_overlap_checker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Expected result word for one accepted command; updates the store buffer
	function automatic res_t next_verdict(cmd_t c);
		res_t        r;
		int          i;
		int          pos;
		bit          stop;
		logic [3:0]  big;
		logic [2:0]  diff;
		r = '0;
		stop = 1'b0;
		case (c.kind)
			KIND_STORE: begin
				if (buf_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					buf_addr[buf_fill] = c.addr;
					buf_size[buf_fill] = c.nbytes;
					buf_fill++;
				end
			end
			KIND_LOAD: begin
				// newest first, stop at first overlap, bad size or end of buffer
				for (i = 0; i < int'(c.stores_to_check) && !stop; i++) begin
					if (i >= buf_fill) begin
						r.status = ST_FEW;
						stop = 1'b1;
					end else begin
						pos = buf_fill - 1 - i;
						big = (buf_size[pos] >= c.nbytes) ? buf_size[pos] : c.nbytes;
						diff = buf_addr[pos][2:0] ^ c.addr[2:0];
						if (buf_addr[pos][ADDR_W-1:3] == c.addr[ADDR_W-1:3]) begin
							stop = 1'b1;
							case (big)
								4'd8: r.conflict = 1'b1;
								4'd4: r.conflict = !diff[2];
								4'd2: r.conflict = (diff[2:1] == 2'b00);
								4'd1: r.conflict = (diff == 3'b000);
								default: r.status = ST_BADSIZE;
							endcase
							if (!r.conflict && r.status == ST_OK)
								stop = 1'b0;
						end
					end
				end
				if (mode_now == MODE_NEVER)
					r.conflict = 1'b0;
				else if (mode_now == MODE_ALWAYS)
					r.conflict = 1'b1;
			end
			KIND_FLUSH: buf_fill = 0;
			default: ;
		endcase
		return r;
	endfunction

	// Mostly legal sizes, sometimes any 4-bit value
	function automatic logic [3:0] pick_size();
		if ($urandom_range(9) != 0)
			return 4'd1 << $urandom_range(3);
		return 4'($urandom_range(15));
	endfunction

	// Address in the same word as base, sometimes a neighbor word or anywhere
	function automatic logic [31:0] near(logic [31:0] base);
		case ($urandom_range(9))
			0: return $urandom;
			1: return base ^ 32'h8;
			default: return {base[31:3], 3'($urandom_range(7))};
		endcase
	endfunction

	task automatic add_cmd(logic [1:0] kind, logic [31:0] addr, logic [3:0] size,
			logic [6:0] cnt);
		stim_t e;
		e = '0;
		e.c.kind = kind;
		e.c.addr = addr;
		e.c.nbytes = size;
		e.c.stores_to_check = cnt;
		e.idle_pct = 7'(gap_pct);
		cmd_q.push_back(e);
		n_made++;
		if (kind == KIND_STORE && gen_fill < DEPTH)
			gen_fill++;
		else if (kind == KIND_FLUSH)
			gen_fill = 0;
	endtask

	task automatic add_mode(logic [1:0] m);
		stim_t e;
		e = '0;
		e.is_cfg = 1'b1;
		e.mode = m;
		cmd_q.push_back(e);
	endtask

	// Driver: completes handshakes, then presents the next word or mode write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= MODE_REAL;
		end else begin
			if (start && !busy) begin
				verdict_q.push_back(next_verdict(cmd));
				n_sent++;
			end
			if (cfg_valid && cfg_ready)
				mode_now = cfg_data;
			if ((start && busy) || (cfg_valid && !cfg_ready)) begin
				// hold current word
			end else if (cmd_q.size() != 0 && cmd_q[0].is_cfg) begin
				// mode writes only with the block idle
				start <= 1'b0;
				if (n_sent == n_seen && !start && !busy && !cfg_valid) begin
					cfg_valid <= 1'b1;
					cfg_data <= cmd_q[0].mode;
					cmd_q.delete(0);
				end else begin
					cfg_valid <= 1'b0;
				end
			end else if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
				cfg_valid <= 1'b0;
				start <= 1'b1;
				cmd <= cmd_q[0].c;
				cmd_q.delete(0);
			end else begin
				cfg_valid <= 1'b0;
				start <= 1'b0;
			end
		end
	end

	// Monitor: each strobed result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result word: conflict %0d status %0d",
					result.conflict, result.status);
				n_fail++;
			end else begin
				want = verdict_q[0];
				verdict_q.delete(0);
				if (result.conflict !== want.conflict) begin
					$error("conflict: expected %0d, got %0d", want.conflict, result.conflict);
					n_fail++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					n_fail++;
				end
				n_seen <= n_seen + 1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [1:0]  modes [8];
		logic [31:0] base;
		int          ph;
		int          goal;
		int          pick;
		int          k;
		int          n;
		int          w;
		modes = '{MODE_REAL, MODE_REAL_ALT, MODE_NEVER, MODE_ALWAYS,
			MODE_REAL, MODE_ALWAYS, MODE_REAL_ALT, MODE_NEVER};

		// directed: empty buffer, size rules, word boundaries, kinds
		add_mode(MODE_REAL);
		add_cmd(KIND_LOAD, 32'h0, 4'd1, 7'd5);
		add_cmd(KIND_LOAD, 32'h0, 4'd1, 7'd0);
		add_cmd(KIND_STORE, 32'hFFFF_FFF8, 4'd8, 7'd0);
		add_cmd(KIND_STORE, 32'h3, 4'd1, 7'd127);
		add_cmd(KIND_LOAD, 32'h3, 4'd1, 7'd1);
		add_cmd(KIND_LOAD, 32'h2, 4'd1, 7'd2);
		add_cmd(KIND_LOAD, 32'h2, 4'd1, 7'd3);
		add_cmd(KIND_LOAD, 32'hFFFF_FFFF, 4'd2, 7'd2);
		add_cmd(KIND_STORE, 32'h5, 4'd3, 7'd0);
		add_cmd(KIND_LOAD, 32'h4, 4'd1, 7'd1);
		add_cmd(KIND_LOAD, 32'h10, 4'd0, 7'd3);
		add_cmd(KIND_LOAD, 32'h1, 4'd15, 7'd2);
		add_cmd(KIND_STORE, 32'h4, 4'd4, 7'd0);
		add_cmd(KIND_LOAD, 32'h0, 4'd4, 7'd1);
		add_cmd(KIND_LOAD, 32'h6, 4'd2, 7'd1);
		add_cmd(KIND_LOAD, 32'h6, 4'd1, 7'd3);
		add_cmd(KIND_NONE, 32'hFFFF_FFFF, 4'd15, 7'd127);
		add_cmd(KIND_FLUSH, 32'h0, 4'd0, 7'd0);
		add_cmd(KIND_LOAD, 32'h4, 4'd4, 7'd127);
		add_cmd(KIND_STORE, 32'h0, 4'd2, 7'd0);
		add_cmd(KIND_LOAD, 32'h1, 4'd2, 7'd1);
		add_cmd(KIND_LOAD, 32'h2, 4'd1, 7'd64);

		// random phases: one mode each, sender gaps 21%, then 76%, then none
		for (ph = 0; ph < 8; ph++) begin
			gap_pct = (ph < 3) ? 21 : (ph < 6) ? 76 : 0;
			add_mode(modes[ph]);
			goal = n_made + 250;
			pick = (ph == 0) ? 99 : 0;
			while (n_made < goal) begin
				base = $urandom;
				if (pick == 99 || $urandom_range(9) == 0) begin
					// long store run to reach a full buffer
					add_cmd(KIND_FLUSH, $urandom, pick_size(), 7'($urandom));
					n = $urandom_range(60, 72);
					for (k = 0; k < n; k++)
						add_cmd(KIND_STORE, near(base), pick_size(), 7'($urandom));
					for (k = 0; k < 4; k++)
						add_cmd(KIND_LOAD, near(base), pick_size(), 7'($urandom_range(40, 127)));
				end else if ($urandom_range(99) < 60) begin
					// stores then loads on one word
					if ($urandom_range(2) == 0)
						add_cmd(KIND_FLUSH, $urandom, pick_size(), 7'($urandom));
					n = $urandom_range(1, 8);
					for (k = 0; k < n; k++)
						add_cmd(KIND_STORE, near(base), pick_size(), 7'($urandom));
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						add_cmd(KIND_LOAD, near(base), pick_size(),
							7'($urandom_range(0, (gen_fill + 2 > 127) ? 127 : gen_fill + 2)));
				end else begin
					// noise: any kind, any field value
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++)
						add_cmd(2'($urandom), $urandom, 4'($urandom), 7'($urandom));
				end
				pick = 0;
			end
		end

		// reset once, released away from the clock edge
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_q.size() != 0 || start)
			@(posedge clk);
		for (w = 0; w < 200 && n_seen != n_sent; w++)
			@(posedge clk);
		repeat (70) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d result words never arrived", verdict_q.size());
			n_fail++;
		end
		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit
	initial begin
		#(20 * 3000000);
		$display("FAIL");
		$finish;
	end

endmodule
